// ===== rtl/bmsr_pkg.sv =====
// Shared constants, codes and control types for the binary mask speckle remover.
package bmsr_pkg;

  // Frame limits
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  // Configuration register width
  localparam int DIM_W = 12;

  // Window geometry
  localparam int WIN_N     = 5;
  localparam int STACK_W   = WIN_N - 1;
  localparam int CTR_POS   = WIN_N / 2;
  localparam int OUT_POS   = CTR_POS - 1;
  localparam int CTR_START = WIN_N - 1;
  localparam int MIN_DIM   = WIN_N;

  // Output lags arrival by three rows and three columns
  localparam int LAT_ROWS = 3;
  localparam int LAT_COLS = 3;

  // Centers skipped after a black center
  localparam int SKIP_CNT = 2;
  localparam int SKIP_W   = $clog2(SKIP_CNT + 1);

  // Counter and dimension widths
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
  localparam int HEFF_W = $clog2(MAX_HEIGHT + 1);
  localparam int OROW_W = $clog2(MAX_HEIGHT);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + LAT_ROWS + 1);
  localparam int CMP_W  = 32;

  // Register values after reset
  localparam logic [DIM_W-1:0] RST_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0] RST_HEIGHT = DIM_W'(480);

  // Register indexes
  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Input beat kinds
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  // Control from the sequencer to the cell window
  typedef struct packed {
    logic shift;
    logic visit;
    logic skip_clear;
    logic restart;
  } win_ctrl_t;

endpackage

// ===== rtl/bmsr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bmsr_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/bmsr_cell.sv =====
// One pixel cell of the window: takes its right neighbor on a shift, can be forced white.
module bmsr_cell (
  input  logic clk,
  input  logic en,
  input  logic d,
  input  logic set_white,
  output logic q
);

  always_ff @(posedge clk) begin
    if (en) begin
      q <= d | set_white;
    end
  end

endmodule

// ===== rtl/bmsr_window.sv =====
// 5x5 window of pixel cells with the ring test, inner-block clear and center skip count.
module bmsr_window (
  input  logic                         clk,
  input  logic                         rst,
  input  bmsr_pkg::win_ctrl_t          ctrl,
  input  logic [bmsr_pkg::WIN_N-1:0]   col_in,
  output logic [bmsr_pkg::STACK_W-1:0] wb_col,
  output logic                         out_px
);
  import bmsr_pkg::*;

  logic              q        [WIN_N][WIN_N];
  logic              s        [WIN_N][WIN_N];
  logic              blk_set  [WIN_N][WIN_N];
  logic [SKIP_W-1:0] skip_left;
  logic [SKIP_W-1:0] skip_left_next;
  logic [SKIP_W-1:0] skip_eff;
  logic              ring_ok;
  logic              center_black;
  logic              visit_live;
  logic              clear_hit;

  // Shifted view: every column moves left, new column enters on the right
  for (genvar r = 0; r < WIN_N; r++) begin : g_row
    for (genvar c = 0; c < WIN_N; c++) begin : g_col
      if (c == WIN_N - 1) begin : g_edge
        assign s[r][c] = col_in[r];
      end else begin : g_mid
        assign s[r][c] = q[r][c+1];
      end

      // Inner 3x3 block around the center gets the clear
      if (r >= 1 && r <= WIN_N - 2 && c >= 1 && c <= WIN_N - 2) begin : g_blk
        assign blk_set[r][c] = clear_hit;
      end else begin : g_noblk
        assign blk_set[r][c] = 1'b0;
      end

      bmsr_cell u_cell (
        .clk       (clk),
        .en        (ctrl.shift),
        .d         (s[r][c]),
        .set_white (blk_set[r][c]),
        .q         (q[r][c])
      );
    end
  end

  // Outer ring at radius two must be all white
  always_comb begin
    ring_ok = 1'b1;
    for (int i = 0; i < WIN_N; i++) begin
      ring_ok = ring_ok & s[0][i] & s[WIN_N-1][i] & s[i][0] & s[i][WIN_N-1];
    end
  end

  // Center test and skip count
  always_comb begin
    skip_eff     = ctrl.skip_clear ? '0 : skip_left;
    center_black = !s[CTR_POS][CTR_POS];
    visit_live   = ctrl.visit && (skip_eff == '0);
    clear_hit    = visit_live && center_black && ring_ok;

    skip_left_next = skip_left;
    if (ctrl.restart) begin
      skip_left_next = '0;
    end else if (ctrl.visit) begin
      if (skip_eff != '0) begin
        skip_left_next = skip_eff - 1'b1;
      end else if (center_black) begin
        skip_left_next = SKIP_W'(SKIP_CNT);
      end else begin
        skip_left_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_left <= '0;
    end else begin
      skip_left <= skip_left_next;
    end
  end

  // Leaving column goes back to the line memory, rows moved up by one
  for (genvar k = 0; k < STACK_W; k++) begin : g_wb
    assign wb_col[k] = q[k+1][0];
  end

  // Final pixel three rows and three columns behind arrival
  assign out_px = s[OUT_POS][OUT_POS] | clear_hit;

endmodule

// ===== rtl/binary_mask_speckle_remover_top.sv =====
// Top level of the binary mask speckle remover: counters, line memory, window, output stage.
//
//   Channel | Signals                          | Dir | Beat
//   cfg     | cfg_valid cfg_ready cfg_index    | in  | one register write
//           | cfg_data                         |     |
//   in      | in_valid in_ready op pixel_white | in  | one pixel or drain tick
//   out     | out_valid out_ready clean_white  | out | one final pixel
//           | frame_end                        |     |
//
// One input beat per clock and one output beat per clock, sustained while out_ready is high.
// The pixel at raster position p leaves on the output register loaded by the beat at
// position p + 3*W + 3; the 5x5 cell window and one line memory port pair set this.
// Reset is synchronous: 640x480, counters at frame start; line memory is not cleared.
// in_ready drops only while the output register is full and out_ready is low.
module binary_mask_speckle_remover_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [bmsr_pkg::DIM_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       op,
  input  logic                       pixel_white,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       clean_white,
  output logic                       frame_end
);
  import bmsr_pkg::*;

  logic [DIM_W-1:0]   frame_width;
  logic [DIM_W-1:0]   frame_height;
  logic [WEFF_W-1:0]  w_eff;
  logic [HEFF_W-1:0]  h_eff;
  logic [COL_W-1:0]   in_col;
  logic [COL_W-1:0]   in_col_next;
  logic [ROW_W-1:0]   in_row;
  logic [ROW_W-1:0]   in_row_next;
  logic [COL_W-1:0]   out_col;
  logic [COL_W-1:0]   out_col_next;
  logic [OROW_W-1:0]  out_row;
  logic [OROW_W-1:0]  out_row_next;
  logic               cfg_acc;
  logic               in_acc;
  logic               in_frame;
  logic               past_lat;
  logic               advance;
  logic               emit;
  logic               last;
  logic               restart;
  logic               out_valid_next;
  logic [COL_W-1:0]   wr_addr;
  logic [STACK_W-1:0] wb_col;
  logic [STACK_W-1:0] ram_q;
  logic [STACK_W-1:0] mem_col;
  logic               fwd_hit;
  logic [STACK_W-1:0] fwd_data;
  logic               win_px;
  win_ctrl_t          ctrl;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_ready  = !out_valid || out_ready;
  assign in_acc    = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_WIDTH;
      frame_height <= RST_HEIGHT;
    end else if (cfg_acc) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame size clamped to the legal range
  always_comb begin
    if (frame_width < DIM_W'(MIN_DIM)) begin
      w_eff = WEFF_W'(MIN_DIM);
    end else if (CMP_W'(frame_width) > CMP_W'(MAX_WIDTH)) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(frame_width);
    end
    if (frame_height < DIM_W'(MIN_DIM)) begin
      h_eff = HEFF_W'(MIN_DIM);
    end else if (CMP_W'(frame_height) > CMP_W'(MAX_HEIGHT)) begin
      h_eff = HEFF_W'(MAX_HEIGHT);
    end else begin
      h_eff = HEFF_W'(frame_height);
    end
  end

  // Beat decode
  always_comb begin
    in_frame = in_row < ROW_W'(h_eff);
    past_lat = (in_row > ROW_W'(LAT_ROWS)) ||
               ((in_row == ROW_W'(LAT_ROWS)) && (in_col >= COL_W'(LAT_COLS)));
    // Drain ticks inside the frame are dropped
    advance  = in_acc && !(in_frame && (op == OP_DRAIN));
    emit     = advance && past_lat;
    last     = (out_row == OROW_W'(h_eff - 1'b1)) && (out_col == COL_W'(w_eff - 1'b1));
    restart  = cfg_acc || (emit && last);

    ctrl.shift      = advance;
    ctrl.visit      = advance && in_frame && (in_row >= ROW_W'(CTR_START)) &&
                      (in_col >= COL_W'(CTR_START));
    ctrl.skip_clear = in_col == COL_W'(CTR_START);
    ctrl.restart    = restart;
  end

  // Arrival and departure position counters
  always_comb begin
    in_col_next  = in_col;
    in_row_next  = in_row;
    out_col_next = out_col;
    out_row_next = out_row;
    if (restart) begin
      in_col_next  = '0;
      in_row_next  = '0;
      out_col_next = '0;
      out_row_next = '0;
    end else if (advance) begin
      if (in_col == COL_W'(w_eff - 1'b1)) begin
        in_col_next = '0;
        in_row_next = in_row + 1'b1;
      end else begin
        in_col_next = in_col + 1'b1;
      end
      if (emit) begin
        if (out_col == COL_W'(w_eff - 1'b1)) begin
          out_col_next = '0;
          out_row_next = out_row + 1'b1;
        end else begin
          out_col_next = out_col + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
    end
  end

  // Column leaving the window belongs five positions back, wrapped within the row
  always_comb begin
    if (in_col >= COL_W'(WIN_N)) begin
      wr_addr = in_col - COL_W'(WIN_N);
    end else begin
      wr_addr = COL_W'(WEFF_W'(in_col) + w_eff - WEFF_W'(WIN_N));
    end
  end

  // Line memory: one 4-row column stack per column
  bmsr_ram #(
    .WIDTH (STACK_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (advance),
    .wr_addr (wr_addr),
    .wr_data (wb_col),
    .rd_addr (in_col_next),
    .rd_data (ram_q)
  );

  // Same-edge write forward, needed at width six
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= advance && (wr_addr == in_col_next);
    end
    fwd_data <= wb_col;
  end

  // At width five the leaving column is the next entering stack
  always_comb begin
    if (w_eff == WEFF_W'(MIN_DIM)) begin
      mem_col = wb_col;
    end else if (fwd_hit) begin
      mem_col = fwd_data;
    end else begin
      mem_col = ram_q;
    end
  end

  bmsr_window u_window (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .col_in ({pixel_white, mem_col}),
    .wb_col (wb_col),
    .out_px (win_px)
  );

  // Output register
  always_comb begin
    if (emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
    if (emit) begin
      clean_white <= win_px;
      frame_end   <= last;
    end
  end

  // Checks
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    WEFF_W'(in_col) < w_eff)
    else $error("arrival column outside frame width");

  a_out_row_range: assert property (@(posedge clk) disable iff (rst)
    HEFF_W'(out_row) < h_eff)
    else $error("departure row outside frame height");

  a_fwd_after_write: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> $past(advance))
    else $error("forward hit without a line memory write");

  a_tail_emits: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !in_frame) |=> out_valid)
    else $error("tail beat produced no output");

endmodule
